/* rtl/fem_pkg.sv */
// Shared types and constants of the file extent map.
package fem_pkg;

    localparam int MAX_EXTENTS_DEFAULT = 64;
    localparam int RES_CAP             = 64;
    localparam int IDX_W               = 6;
    localparam int ADDR_W              = 48;
    localparam int LEN_W               = 32;
    localparam int DEV_W               = 8;
    localparam int NOUT_W              = $clog2(RES_CAP) + 1;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_SEEK   = 2'd1,
        FUNC_DELTA  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [DEV_W-1:0]   in_device;
        logic [ADDR_W-1:0]  in_start;
        logic [LEN_W-1:0]   in_length;
        logic [ADDR_W-1:0]  file_offset;
        logic [ADDR_W-1:0]  committed_point;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   extent_index;
        logic [DEV_W-1:0]   out_device;
        logic [ADDR_W-1:0]  out_start;
        logic [LEN_W-1:0]   out_length;
        logic [LEN_W-1:0]   within_offset;
        logic               last;
    } rsp_t;

    // One table row: the extent itself and the file offset at which it begins.
    typedef struct packed {
        logic [DEV_W-1:0]   device;
        logic [ADDR_W-1:0]  start;
        logic [LEN_W-1:0]   length;
        logic [ADDR_W-1:0]  fstart;
    } entry_t;

    // Operand selection of the shared adder.
    typedef struct packed {
        logic               sub;
        logic [ADDR_W-1:0]  a;
        logic [ADDR_W-1:0]  b;
    } alu_op_t;

endpackage

/* rtl/fem_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fem_alu.sv */
// Shared 48-bit adder/subtractor with borrow out, used by the sequencer's arithmetic steps.
module fem_alu
    import fem_pkg::*;
(
    input  alu_op_t           op,
    output logic [ADDR_W:0]   result
);

    always_comb
    begin
        if (op.sub)
        begin
            result = {1'b0, op.a} - {1'b0, op.b};
        end
        else
        begin
            result = {1'b0, op.a} + {1'b0, op.b};
        end
    end

endmodule

/* rtl/file_extent_map.sv */
// Top level of the file extent map: sequencer, extent table and shared adder.
//
// The req channel carries one command per transfer (append, seek, delta or
// clear); the rsp channel returns its results, last set on the final one.
// Both channels use valid/ready. req_ready is high only while the sequencer
// is idle; the block works on one command at a time. Its steps share
// one 48-bit adder/subtractor and one table RAM with a registered read.
// A seek is a binary search over the rows' file offsets. A delta walks the
// rows from the first, skips each fully committed extent, then returns one
// result per later extent, the first trimmed at the committed point.
// req_ready returns in the same cycle as the final result enters the output
// register. A full table answers an append with a table-full status; a seek
// past the end and a delta with nothing past the committed point answer
// not-found. Reset empties the table at once: the count and the running
// total clear, and table rows are never read before they are written.
// Results sit in an output register; when the receiver stalls, the
// sequencer holds the next result until that register is taken.
module file_extent_map
    import fem_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = $bits(entry_t);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_APPEND   = 11'b000_0000_0010,
        S_SEEK_CHK = 11'b000_0000_0100,
        S_SEEK_MID = 11'b000_0000_1000,
        S_SEEK_CMP = 11'b000_0001_0000,
        S_SEEK_HIT = 11'b000_0010_0000,
        S_DELTA_D  = 11'b000_0100_0000,
        S_DELTA_E  = 11'b000_1000_0000,
        S_DELTA_S  = 11'b001_0000_0000,
        S_DELTA_L  = 11'b010_0000_0000,
        S_RESULT   = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]   total_reg, total_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [NOUT_W-1:0]   nout_reg, nout_next;

    req_t                item_reg, item_next;
    logic [IW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [ADDR_W:0]     d_reg, d_next;
    logic [LEN_W-1:0]    skip_reg, skip_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;

    alu_op_t             alu_op;
    logic [ADDR_W:0]     alu_res;
    logic                ram_we;
    entry_t              wr_entry;
    entry_t              rd_entry;
    logic [EW-1:0]       rd_bits;
    logic [CW:0]         lo_plus_hi;
    logic [CW-1:0]       addr_plus1;
    logic                at_end;
    logic                load_rsp;

    fem_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EXTENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IW'(count_reg)),
        .wdata (EW'(wr_entry)),
        .raddr (addr_next),
        .rdata (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);

    fem_alu u_alu (
        .op     (alu_op),
        .result (alu_res)
    );

    assign wr_entry.device = item_reg.in_device;
    assign wr_entry.start  = item_reg.in_start;
    assign wr_entry.length = item_reg.in_length;
    assign wr_entry.fstart = total_reg;

    assign lo_plus_hi = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign addr_plus1 = CW'(addr_reg) + CW'(1);
    assign at_end     = (addr_plus1 == count_reg);
    assign load_rsp   = (state_reg == S_RESULT) && (!rsp_valid_reg || rsp_ready);

    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign ram_we     = (state_reg == S_APPEND);

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_op.sub = 1'b1;
        alu_op.a   = '0;
        alu_op.b   = '0;
        unique case (state_reg)
            S_APPEND:
            begin
                alu_op.sub = 1'b0;
                alu_op.a   = total_reg;
                alu_op.b   = ADDR_W'(item_reg.in_length);
            end
            S_SEEK_CHK:
            begin
                alu_op.a = item_reg.file_offset;
                alu_op.b = total_reg;
            end
            S_SEEK_CMP, S_SEEK_HIT:
            begin
                alu_op.a = item_reg.file_offset;
                alu_op.b = rd_entry.fstart;
            end
            S_DELTA_D:
            begin
                alu_op.a = item_reg.committed_point;
                alu_op.b = rd_entry.fstart;
            end
            S_DELTA_E:
            begin
                alu_op.a = d_reg[ADDR_W-1:0];
                alu_op.b = ADDR_W'(rd_entry.length);
            end
            S_DELTA_S:
            begin
                alu_op.sub = 1'b0;
                alu_op.a   = rd_entry.start;
                alu_op.b   = ADDR_W'(skip_reg);
            end
            S_DELTA_L:
            begin
                alu_op.a = ADDR_W'(rd_entry.length);
                alu_op.b = ADDR_W'(skip_reg);
            end
            default:
            begin
                alu_op.sub = 1'b1;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        nout_next      = nout_reg;
        item_next      = item_reg;
        addr_next      = addr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        d_next         = d_reg;
        skip_next      = skip_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_rsp)
        begin
            rsp_next       = res_reg;
            rsp_valid_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                res_next        = '0;
                res_next.status = ST_OK;
                res_next.last   = 1'b1;
                if (req_valid)
                begin
                    item_next = req;
                    addr_next = '0;
                    nout_next = '0;
                    unique case (req.func)
                        FUNC_APPEND:
                        begin
                            if (count_reg == CW'(MAX_EXTENTS))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_APPEND;
                            end
                        end
                        FUNC_SEEK:
                        begin
                            state_next = S_SEEK_CHK;
                        end
                        FUNC_DELTA:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NOT_FOUND;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_DELTA_D;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPEND:
            begin
                total_next            = alu_res[ADDR_W-1:0];
                count_next            = count_reg + CW'(1);
                res_next.extent_index = IDX_W'(count_reg);
                res_next.out_device   = item_reg.in_device;
                res_next.out_start    = item_reg.in_start;
                res_next.out_length   = item_reg.in_length;
                state_next            = S_RESULT;
            end
            S_SEEK_CHK:
            begin
                // No borrow means the offset is at or past the end of the file.
                if (count_reg == '0 || !alu_res[ADDR_W])
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_RESULT;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SEEK_MID;
                end
            end
            S_SEEK_MID:
            begin
                if ((CW'(lo_reg) + CW'(1)) < hi_reg)
                begin
                    addr_next  = IW'(lo_plus_hi[CW:1]);
                    state_next = S_SEEK_CMP;
                end
                else
                begin
                    addr_next  = IW'(lo_reg);
                    state_next = S_SEEK_HIT;
                end
            end
            S_SEEK_CMP:
            begin
                // Keep the last start at or below the offset as the lower bound.
                if (!alu_res[ADDR_W])
                begin
                    lo_next = CW'(addr_reg);
                end
                else
                begin
                    hi_next = CW'(addr_reg);
                end
                state_next = S_SEEK_MID;
            end
            S_SEEK_HIT:
            begin
                res_next.extent_index  = IDX_W'(addr_reg);
                res_next.out_device    = rd_entry.device;
                res_next.out_start     = rd_entry.start;
                res_next.out_length    = rd_entry.length;
                res_next.within_offset = alu_res[LEN_W-1:0];
                state_next             = S_RESULT;
            end
            S_DELTA_D:
            begin
                d_next     = alu_res;
                state_next = S_DELTA_E;
            end
            S_DELTA_E:
            begin
                if (d_reg[ADDR_W])
                begin
                    // The extent starts past the committed point.
                    skip_next  = '0;
                    state_next = S_DELTA_S;
                end
                else if (!alu_res[ADDR_W])
                begin
                    // Fully committed: move on to the next extent.
                    if (at_end)
                    begin
                        if (nout_reg == '0)
                        begin
                            res_next.status = ST_NOT_FOUND;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        addr_next  = IW'(addr_plus1);
                        state_next = S_DELTA_D;
                    end
                end
                else
                begin
                    skip_next  = d_reg[LEN_W-1:0];
                    state_next = S_DELTA_S;
                end
            end
            S_DELTA_S:
            begin
                res_next.out_start = alu_res[ADDR_W-1:0];
                state_next         = S_DELTA_L;
            end
            S_DELTA_L:
            begin
                // Once one extent is emitted, every later one is emitted too, up to RES_CAP results.
                res_next.status        = ST_OK;
                res_next.extent_index  = IDX_W'(addr_reg);
                res_next.out_device    = rd_entry.device;
                res_next.out_length    = alu_res[LEN_W-1:0];
                res_next.within_offset = '0;
                res_next.last          = at_end || (nout_reg == NOUT_W'(RES_CAP - 1));
                state_next             = S_RESULT;
            end
            S_RESULT:
            begin
                if (load_rsp)
                begin
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        nout_next  = nout_reg + NOUT_W'(1);
                        addr_next  = IW'(addr_plus1);
                        state_next = S_DELTA_D;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            nout_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            nout_reg      <= nout_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        addr_reg <= addr_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        d_reg    <= d_next;
        skip_reg <= skip_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

endmodule
